// ----- rtl/assert_macros.svh -----
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, prop, msg)
`endif
`endif

// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
package pfa_pkg;
  localparam logic [63:0] GlP   = 64'hFFFF_FFFF_0000_0001;
  localparam logic [63:0] GlEps = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] GlInvExp = 64'hFFFF_FFFE_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_NEG = 3'd3,
    CMD_INV = 3'd4, CMD_DIV = 3'd5, CMD_POW = 3'd6, CMD_NOP = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_ZERO = 2'd1, ERR_RANGE = 2'd2
  } err_e;

  // multiplier operand selection for a multiply
  typedef enum logic [1:0] {
    MS_SQR = 2'd0, MS_BASE = 2'd1, MS_A = 2'd2
  } msel_e;

  typedef struct packed {
    logic  load;      // capture operands
    logic  acc_one;   // set accumulator to one
    logic  mul_go;    // launch multiply
    msel_e msel;      // multiply operand pair
    logic  bit_shift; // advance exponent
    logic  fin;       // present result
  } ctl_t;

  typedef struct packed {
    logic       mul_done;
    logic       exp_bit;
    logic       last_bit;
    logic [2:0] cmd;
    logic [1:0] err;
  } sts_t;

  function automatic logic [63:0] gl_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = s[63:0];
    if (s[64]) r = r + GlEps;
    if (r >= GlP) r = r - GlP;
    return r;
  endfunction

  function automatic logic [63:0] gl_sub(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a < b) d = d - GlEps;
    return d;
  endfunction
endpackage

// ----- rtl/pfa_mul.sv -----
`timescale 1ns / 1ps
// Multi-cycle modular multiplier: four 32x32 partial products, then reduce.
module pfa_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] x_i,
  input  logic [63:0] y_i,
  output logic        done_o,
  output logic [63:0] p_o
);
  import pfa_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b0_0001, StPp = 5'b0_0010, StAcc = 5'b0_0100, StRed = 5'b0_1000,
    StFin  = 5'b1_0000
  } step_e;

  step_e        step_q, step_d;
  logic [63:0]  x_q, y_q;
  logic [127:0] prod_q;
  logic [63:0]  pp_q;
  logic [1:0]   k_q;
  logic [63:0]  t0_q, t1_q;
  logic [63:0]  res_q;
  logic         done_q;

  logic [31:0] xa, yb;
  always_comb begin
    xa = k_q[0] ? x_q[63:32] : x_q[31:0];
    yb = k_q[1] ? y_q[63:32] : y_q[31:0];
  end

  logic [63:0] top, low32, t0c, t2;
  logic [64:0] t2s;
  always_comb begin
    top   = {32'd0, prod_q[127:96]};
    low32 = {32'd0, prod_q[95:64]};
    t0c   = prod_q[63:0] - top;
    if (prod_q[63:0] < top) t0c = t0c - GlEps;
    t2s = {1'b0, t0_q} + {1'b0, t1_q};
    t2  = t2s[63:0];
    if (t2s[64]) t2 = t2 + GlEps;
    if (t2 >= GlP) t2 = t2 - GlP;
  end

  // sequence: one partial product and one accumulate per step
  always_comb begin
    step_d = step_q;
    unique case (step_q)
      StIdle: if (go_i) step_d = StPp;
      StPp:   step_d = StAcc;
      StAcc:  step_d = (k_q == 2'd3) ? StRed : StPp;
      StRed:  step_d = StFin;
      default: step_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
      done_q <= 1'b0;
      k_q    <= 2'd0;
    end else begin
      step_q <= step_d;
      done_q <= (step_q == StFin);
      if (step_q == StIdle) k_q <= 2'd0;
      else if (step_q == StAcc) k_q <= k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == StIdle && go_i) begin
      x_q <= x_i;
      y_q <= y_i;
      prod_q <= '0;
    end
    if (step_q == StPp) pp_q <= xa * yb;
    if (step_q == StAcc)
      prod_q <= prod_q + ({64'd0, pp_q} << ({5'd0, k_q[0]} + {5'd0, k_q[1]}) * 32);
    if (step_q == StRed) begin
      t0_q <= t0c;
      t1_q <= (low32 << 32) - low32;
    end
    if (step_q == StFin) res_q <= t2;
  end

  assign done_o = done_q;
  assign p_o    = res_q;

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_go_busy, clk_i, rst_ni, go_i && step_q != StIdle, "mul launched busy")
  `ASSERT_CLK(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "done held")
  `ASSERT_CLK(a_fin_done, clk_i, rst_ni, (step_q == StFin) |=> done_q, "done missing")
endmodule

// ----- rtl/pfa_datapath.sv -----
`timescale 1ns / 1ps
// Operand registers, accumulator, exponent shifter and error check.
module pfa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfa_pkg::ctl_t       ctl_i,
  input  logic [2:0]          cmd_i,
  input  logic [63:0]         operand_a_i,
  input  logic [63:0]         operand_b_i,
  output pfa_pkg::sts_t       sts_o,
  output logic [63:0]         field_result_o,
  output logic [1:0]          error_code_o
);
  import pfa_pkg::*;

  logic [2:0]  cmd_q;
  logic [63:0] a_q, base_q, exp_q, acc_q, res_q;
  logic [1:0]  err_q, eres_q;
  logic [5:0]  bit_q;
  logic [63:0] mx, my, mp;
  logic        mdone;

  always_comb begin
    case (ctl_i.msel)
      MS_BASE: begin mx = acc_q; my = base_q; end
      MS_A:    begin mx = acc_q; my = a_q; end
      default: begin mx = acc_q; my = acc_q; end
    endcase
  end

  pfa_mul u_mul (
    .clk_i, .rst_ni, .go_i(ctl_i.mul_go), .x_i(mx), .y_i(my), .done_o(mdone), .p_o(mp)
  );

  // range and zero checks at capture
  logic a_bad, b_bad;
  logic [1:0] err_d;
  always_comb begin
    a_bad = operand_a_i >= GlP;
    b_bad = operand_b_i >= GlP;
    err_d = ERR_OK;
    case (cmd_i) inside
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (a_bad || b_bad) err_d = ERR_RANGE;
        else if (cmd_i == CMD_DIV && operand_b_i == 64'd0) err_d = ERR_ZERO;
      end
      CMD_NEG, CMD_INV, CMD_POW: begin
        if (a_bad) err_d = ERR_RANGE;
        else if (cmd_i == CMD_INV && operand_a_i == 64'd0) err_d = ERR_ZERO;
      end
      default: err_d = ERR_OK;
    endcase
  end

  logic [63:0] simple_r;
  always_comb begin
    case (cmd_q)
      CMD_ADD: simple_r = gl_add(a_q, base_q);
      CMD_SUB: simple_r = gl_sub(a_q, base_q);
      CMD_NEG: simple_r = gl_sub(64'd0, a_q);
      default: simple_r = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      a_q   <= operand_a_i;
      err_q <= err_d;
      bit_q <= 6'd63;
      case (cmd_i)
        CMD_INV: begin base_q <= operand_a_i; exp_q <= GlInvExp; end
        CMD_DIV: begin base_q <= operand_b_i; exp_q <= GlInvExp; end
        CMD_POW: begin base_q <= operand_a_i; exp_q <= operand_b_i; end
        default: begin base_q <= operand_b_i; exp_q <= '0; end
      endcase
      // multiply runs as acc * a with acc = b
      if (cmd_i == CMD_MUL) acc_q <= operand_b_i;
    end
    if (ctl_i.acc_one) acc_q <= 64'd1;
    if (mdone) acc_q <= mp;
    if (ctl_i.bit_shift) begin
      exp_q <= {exp_q[62:0], 1'b0};
      bit_q <= bit_q - 6'd1;
    end
    if (ctl_i.fin) begin
      res_q  <= (err_q != ERR_OK || cmd_q == CMD_NOP) ? 64'd0 : simple_r;
      eres_q <= err_q;
    end
  end

  assign sts_o.mul_done = mdone;
  assign sts_o.exp_bit  = exp_q[63];
  assign sts_o.last_bit = (bit_q == 6'd0);
  assign sts_o.cmd      = cmd_q;
  assign sts_o.err      = err_q;
  assign field_result_o = res_q;
  assign error_code_o   = eres_q;
endmodule

// ----- rtl/pfa_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: optional square-and-multiply over the exponent, then optional final multiply.
module pfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pfa_pkg::sts_t sts_i,
  output pfa_pkg::ctl_t ctl_o,
  output logic          busy_o,
  output logic          done_o
);
  import pfa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001, S_DISP = 8'b0000_0010, S_SQR  = 8'b0000_0100,
    S_SQW  = 8'b0000_1000, S_MB   = 8'b0001_0000, S_MBW  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000, S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   fmul_q, fmul_d; // final multiply by operand a pending

  always_comb begin
    state_d = state_q;
    fmul_d  = fmul_q;
    ctl_o   = '0;
    ctl_o.msel = MS_SQR;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        ctl_o.load = 1'b1;
        state_d = S_DISP;
      end
      S_DISP: begin
        fmul_d = 1'b0;
        if (sts_i.err != ERR_OK) state_d = S_FIN;
        else if (sts_i.cmd == CMD_MUL) begin
          fmul_d = 1'b1;
          state_d = S_MB;
        end else if (sts_i.cmd == CMD_INV || sts_i.cmd == CMD_DIV ||
                     sts_i.cmd == CMD_POW) begin
          ctl_o.acc_one = 1'b1;
          state_d = S_SQR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SQR: begin
        ctl_o.mul_go = 1'b1;
        state_d = S_SQW;
      end
      S_SQW: if (sts_i.mul_done) state_d = sts_i.exp_bit ? S_MB : S_MBW;
      S_MB: begin
        ctl_o.mul_go = 1'b1;
        ctl_o.msel = fmul_q ? MS_A : MS_BASE;
        state_d = S_MBW;
      end
      S_MBW: if (sts_i.mul_done || !sts_i.exp_bit || fmul_q) begin
        // the direct hop from a square with a clear bit skips the wait
        if (fmul_q) begin
          if (sts_i.mul_done) begin
            fmul_d = 1'b0;
            state_d = S_FIN;
          end
        end else if (sts_i.last_bit) begin
          ctl_o.bit_shift = 1'b1;
          state_d = (sts_i.cmd == CMD_DIV) ? S_MB : S_FIN;
          fmul_d = (sts_i.cmd == CMD_DIV);
        end else begin
          ctl_o.bit_shift = 1'b1;
          state_d = S_SQR;
        end
      end
      S_FIN: begin
        ctl_o.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fmul_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fmul_q  <= fmul_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

  `include "assert_macros.svh"
  `ASSERT_CLK(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_CLK(a_out_idle, clk_i, rst_ni, (state_q == S_OUT) |=> (state_q == S_IDLE),
              "result not single")
  `ASSERT_NEVER(a_go_wait, clk_i, rst_ni, ctl_o.mul_go && (state_q == S_SQW),
                "multiply launched while waiting")
endmodule

// ----- rtl/prime_field_alu_goldilocks_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake          Ports
// command   start / busy       cmd_i, operand_a_i, operand_b_i
// result    done_o strobe      field_result_o, error_code_o
//
// Add, sub, neg, cmd 7 and errors go from accept via dispatch and finish to the
// strobe; mul adds one multiply. Power, inverse and divide walk 64 exponent bits:
// each bit costs one square plus one more multiply for a set bit, and divide
// ends with a multiply by a, all through the single shared 32x32 multiplier.
// Reset clears the controller and multiplier sequencers; no clearing pass.
// done_o is high for one cycle; the receiver cannot stall it.
module prime_field_alu_goldilocks_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        done_o,
  output logic [63:0] field_result_o,
  output logic [1:0]  error_code_o
);
  import pfa_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .ctl_o(ctl), .busy_o(busy), .done_o
  );

  pfa_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .cmd_i, .operand_a_i, .operand_b_i,
    .sts_o(sts), .field_result_o, .error_code_o
  );
endmodule
